@@ rtl/bmhq_pkg.sv @@
// Shared constants and codes for the binary min-heap queue.
package bmhq_pkg;

   // Default storage and field widths
   localparam int HEAP_SLOTS_DEF = 128;
   localparam int KEY_BITS_DEF   = 32;
   localparam int TAG_BITS_DEF   = 32;

   // Fixed port widths
   localparam int OP_BITS     = 2;
   localparam int FIELD_BITS  = 32;
   localparam int COUNT_BITS  = 7;
   localparam int STATUS_BITS = 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Slot index ceiling that the 7-bit capacity register can express
   localparam int SLOT_CEIL = 128;

   // Capacity register reset value
   localparam logic [COUNT_BITS-1:0] CAPACITY_RESET = 7'd127;

   // Register index of the capacity register
   localparam logic REG_CAPACITY = 1'b0;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_OVERWRITE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd2;

   // Return frame kinds on the rebalance stack
   localparam logic FR_DOWN = 1'b0;
   localparam logic FR_UP   = 1'b1;

endpackage

@@ rtl/bmhq_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module bmhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/binary_min_heap_queue_top.sv @@
// Binary min-heap priority queue: request/response channels, capacity register, sift sequencer.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | operation, depth_key, tag
//  rsp     | out       | rsp_valid/ready    | head_valid, head_depth, head_tag, entry_count, status
//  csr     | in/out    | psel/penable/pready| capacity at byte address 0
//
// One request at a time. Every heap read during a rebalance uses the single heap read port:
// a level sifted down reads the left child, then the right child if present, compares and swaps
// in two writes; a level sifted up reads the parent, compares, swaps in two writes and rechecks
// the children at the parent; unwinding pops a frame per level. Every request ends with a head read.
// Reset clears the count, the stack pointer and the response valid; the heap store needs no clearing.
// A waiting response holds the next request only at its end, when its result is loaded.
module binary_min_heap_queue_top #(
   parameter int HEAP_SLOTS = bmhq_pkg::HEAP_SLOTS_DEF,
   parameter int KEY_BITS   = bmhq_pkg::KEY_BITS_DEF,
   parameter int TAG_BITS   = bmhq_pkg::TAG_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [bmhq_pkg::OP_BITS-1:0]          req_operation,
   input  logic [bmhq_pkg::FIELD_BITS-1:0]       req_depth_key,
   input  logic [bmhq_pkg::FIELD_BITS-1:0]       req_tag,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_head_valid,
   output logic [bmhq_pkg::FIELD_BITS-1:0]       rsp_head_depth,
   output logic [bmhq_pkg::FIELD_BITS-1:0]       rsp_head_tag,
   output logic [bmhq_pkg::COUNT_BITS-1:0]       rsp_entry_count,
   output logic [bmhq_pkg::STATUS_BITS-1:0]      rsp_status,
   // configuration port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [bmhq_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [bmhq_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [bmhq_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);

   localparam int CW  = bmhq_pkg::COUNT_BITS;
   localparam int EW  = KEY_BITS + TAG_BITS;
   localparam int AW  = $clog2(HEAP_SLOTS);
   localparam int STACK_DEPTH = 2 * HEAP_SLOTS;
   localparam int SW  = $clog2(STACK_DEPTH);
   localparam logic [CW:0] SLOT_LIM = (HEAP_SLOTS < bmhq_pkg::SLOT_CEIL) ?
                                      (CW+1)'(HEAP_SLOTS) : (CW+1)'(bmhq_pkg::SLOT_CEIL);

   typedef enum logic [14:0] {
      S_IDLE = 15'b000000000000001,
      S_DELW = 15'b000000000000010,
      S_BAL  = 15'b000000000000100,
      S_RDL  = 15'b000000000001000,
      S_RDR  = 15'b000000000010000,
      S_DCMP = 15'b000000000100000,
      S_DSW  = 15'b000000001000000,
      S_UP   = 15'b000000010000000,
      S_UCMP = 15'b000000100000000,
      S_USW  = 15'b000001000000000,
      S_RET  = 15'b000010000000000,
      S_POP  = 15'b000100000000000,
      S_PRD  = 15'b001000000000000,
      S_HEAD = 15'b010000000000000,
      S_OUT  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [bmhq_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [CW-1:0] node_ff, node_in;
   logic [CW-1:0] child_ff, child_in;
   logic [EW-1:0] vp_ff, vp_in;
   logic [EW-1:0] vl_ff, vl_in;
   logic [EW-1:0] vc_ff, vc_in;
   logic [SW:0]   sp_ff, sp_in;
   logic [CW-1:0] capacity_ff, capacity_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_head_valid_ff, rsp_head_valid_in;
   logic [bmhq_pkg::FIELD_BITS-1:0]      rsp_head_depth_ff, rsp_head_depth_in;
   logic [bmhq_pkg::FIELD_BITS-1:0]      rsp_head_tag_ff, rsp_head_tag_in;
   logic [CW-1:0]                        rsp_count_ff, rsp_count_in;
   logic [bmhq_pkg::STATUS_BITS-1:0]     rsp_status_ff, rsp_status_in;

   // heap store ports
   logic          hw_en, hr_en;
   logic [AW-1:0] hw_addr, hr_addr;
   logic [EW-1:0] hw_data, h_rdata;
   // stack ports
   logic          sw_en, sr_en;
   logic [SW-1:0] sw_addr, sr_addr;
   logic [1:0]    sw_data, s_rdata;

   logic [CW:0]   limit;
   logic [CW:0]   left_n, right_n;
   logic          csr_wr;
   logic          rsp_free;
   logic [EW-1:0] req_entry;

   // Heap store and return-frame stack
   bmhq_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS)) u_heap (
      .clock   (clock),
      .wr_en   (hw_en),
      .wr_addr (hw_addr),
      .wr_data (hw_data),
      .rd_en   (hr_en),
      .rd_addr (hr_addr),
      .rd_data (h_rdata)
   );

   bmhq_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (sw_en),
      .wr_addr (sw_addr),
      .wr_data (sw_data),
      .rd_en   (sr_en),
      .rd_addr (sr_addr),
      .rd_data (s_rdata)
   );

   // Configuration register
   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == bmhq_pkg::REG_CAPACITY) ?
                   bmhq_pkg::CSR_DATA_BITS'(capacity_ff) : '0;
   assign capacity_in = (csr_wr && paddr[2] == bmhq_pkg::REG_CAPACITY) ?
                        pwdata[CW-1:0] : capacity_ff;

   // Effective slot limit and child indexes
   assign limit   = ({1'b0, capacity_ff} < SLOT_LIM) ? {1'b0, capacity_ff} : SLOT_LIM;
   assign left_n  = {node_ff, 1'b0};
   assign right_n = {node_ff, 1'b1};
   assign req_entry = {req_depth_key[KEY_BITS-1:0], req_tag[TAG_BITS-1:0]};
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Sift sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      node_in   = node_ff;
      child_in  = child_ff;
      vp_in     = vp_ff;
      vl_in     = vl_ff;
      vc_in     = vc_ff;
      sp_in     = sp_ff;
      hw_en = 1'b0;  hw_addr = '0;  hw_data = '0;
      hr_en = 1'b0;  hr_addr = '0;
      sw_en = 1'b0;  sw_addr = sp_ff[SW-1:0];  sw_data = '0;
      sr_en = 1'b0;  sr_addr = '0;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_head_valid_in = rsp_head_valid_ff;
      rsp_head_depth_in = rsp_head_depth_ff;
      rsp_head_tag_in   = rsp_head_tag_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_status_in     = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = bmhq_pkg::ST_OK;
               sp_in     = '0;
               case (req_operation)
                  bmhq_pkg::OP_INSERT: begin
                     // full heap: hold count, overwrite the last slot
                     if (({1'b0, count_ff} + (CW+1)'(1)) >= limit) begin
                        status_in = bmhq_pkg::ST_OVERWRITE;
                        node_in   = count_ff;
                     end else begin
                        count_in = count_ff + CW'(1);
                        node_in  = count_ff + CW'(1);
                     end
                     hw_en   = 1'b1;
                     hw_addr = AW'(node_in);
                     hw_data = req_entry;
                     vp_in   = req_entry;
                     state_in = S_BAL;
                  end
                  bmhq_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = bmhq_pkg::ST_EMPTY;
                        state_in  = S_HEAD;
                     end else begin
                        hr_en    = 1'b1;
                        hr_addr  = AW'(count_ff);
                        state_in = S_DELW;
                     end
                  end
                  bmhq_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_HEAD;
                  end
                  default: state_in = S_HEAD;
               endcase
            end
         end
         // last entry moves to the root
         S_DELW: begin
            hw_en    = 1'b1;
            hw_addr  = AW'(1);
            hw_data  = h_rdata;
            vp_in    = h_rdata;
            count_in = count_ff - CW'(1);
            node_in  = CW'(1);
            state_in = S_BAL;
         end
         // look down: read the left child if it is in range
         S_BAL: begin
            if (left_n < limit && left_n <= {1'b0, count_ff}) begin
               hr_en    = 1'b1;
               hr_addr  = AW'(left_n);
               state_in = S_RDL;
            end else begin
               state_in = S_UP;
            end
         end
         S_RDL: begin
            vl_in = h_rdata;
            if (right_n <= {1'b0, count_ff}) begin
               hr_en    = 1'b1;
               hr_addr  = AW'(right_n);
               state_in = S_RDR;
            end else begin
               child_in = CW'(left_n);
               vc_in    = h_rdata;
               state_in = S_DCMP;
            end
         end
         // right child wins ties
         S_RDR: begin
            if (vl_ff[EW-1 -: KEY_BITS] < h_rdata[EW-1 -: KEY_BITS]) begin
               child_in = CW'(left_n);
               vc_in    = vl_ff;
            end else begin
               child_in = CW'(right_n);
               vc_in    = h_rdata;
            end
            state_in = S_DCMP;
         end
         S_DCMP: begin
            if (vp_ff[EW-1 -: KEY_BITS] > vc_ff[EW-1 -: KEY_BITS]) begin
               hw_en    = 1'b1;
               hw_addr  = AW'(node_ff);
               hw_data  = vc_ff;
               state_in = S_DSW;
            end else begin
               state_in = S_UP;
            end
         end
         // second half of the swap, push a down frame and descend
         S_DSW: begin
            hw_en    = 1'b1;
            hw_addr  = AW'(child_ff);
            hw_data  = vp_ff;
            sw_en    = 1'b1;
            sw_data  = {bmhq_pkg::FR_DOWN, 1'b0};
            sp_in    = sp_ff + (SW+1)'(1);
            node_in  = child_ff;
            state_in = S_BAL;
         end
         // look up at the parent
         S_UP: begin
            if (node_ff >= CW'(2)) begin
               hr_en    = 1'b1;
               hr_addr  = AW'(node_ff >> 1);
               state_in = S_UCMP;
            end else begin
               state_in = S_RET;
            end
         end
         S_UCMP: begin
            if (vp_ff[EW-1 -: KEY_BITS] < h_rdata[EW-1 -: KEY_BITS]) begin
               hw_en    = 1'b1;
               hw_addr  = AW'(node_ff);
               hw_data  = h_rdata;
               state_in = S_USW;
            end else begin
               state_in = S_RET;
            end
         end
         // swap with the parent, push an up frame remembering the side
         S_USW: begin
            hw_en    = 1'b1;
            hw_addr  = AW'(node_ff >> 1);
            hw_data  = vp_ff;
            sw_en    = 1'b1;
            sw_data  = {bmhq_pkg::FR_UP, node_ff[0]};
            sp_in    = sp_ff + (SW+1)'(1);
            node_in  = node_ff >> 1;
            state_in = S_BAL;
         end
         // unwind one frame
         S_RET: begin
            if (sp_ff == '0) begin
               state_in = S_HEAD;
            end else begin
               sr_en    = 1'b1;
               sr_addr  = SW'(sp_ff - (SW+1)'(1));
               sp_in    = sp_ff - (SW+1)'(1);
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (s_rdata[1] == bmhq_pkg::FR_DOWN) begin
               // caller is the parent; refetch its entry, then its up check
               node_in  = node_ff >> 1;
               hr_en    = 1'b1;
               hr_addr  = AW'(node_ff >> 1);
               state_in = S_PRD;
            end else begin
               node_in  = {node_ff[CW-2:0], s_rdata[0]};
               state_in = S_RET;
            end
         end
         S_PRD: begin
            vp_in    = h_rdata;
            state_in = S_UP;
         end
         S_HEAD: begin
            hr_en    = 1'b1;
            hr_addr  = AW'(1);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_head_valid_in = (count_ff != '0);
               rsp_head_depth_in = (count_ff != '0) ?
                  bmhq_pkg::FIELD_BITS'(h_rdata[EW-1 -: KEY_BITS]) : '0;
               rsp_head_tag_in   = (count_ff != '0) ?
                  bmhq_pkg::FIELD_BITS'(h_rdata[TAG_BITS-1:0]) : '0;
               rsp_count_in      = count_ff;
               rsp_status_in     = status_ff;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sp_ff        <= '0;
         capacity_ff  <= bmhq_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      status_ff         <= status_in;
      node_ff           <= node_in;
      child_ff          <= child_in;
      vp_ff             <= vp_in;
      vl_ff             <= vl_in;
      vc_ff             <= vc_in;
      rsp_head_valid_ff <= rsp_head_valid_in;
      rsp_head_depth_ff <= rsp_head_depth_in;
      rsp_head_tag_ff   <= rsp_head_tag_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_head_valid  = rsp_head_valid_ff;
   assign rsp_head_depth  = rsp_head_depth_ff;
   assign rsp_head_tag    = rsp_head_tag_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
